// File: sv/fpt_pkg.sv
// Package for the fan PWM timer controller: item structs, action and register
// codes, reset values and the level-to-duty table.
// No dependencies.
package fpt_pkg;

    // Default width of the PWM counter
    localparam int PWM_COUNTER_BITS_DEF = 10;

    // Width of the duty value and of the configuration data
    localparam int DUTY_W = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W = 3;

    // Action codes carried by an input item
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_LOAD_CD   = 3'd1;
    localparam logic [2:0] ACT_REMOTE    = 3'd2;
    localparam logic [2:0] ACT_SET_CLOCK = 3'd3;
    localparam logic [2:0] ACT_ACK_ALARM = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S  = 3'd5;

    // Control modes
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_REMOTE = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    // Limits
    localparam logic [2:0] LEVEL_MAX  = 3'd4;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd450;

    // Reset values
    localparam logic [6:0] TEMP_HIGH_RST   = 7'd45;
    localparam logic [6:0] TEMP_LOW_RST    = 7'd25;
    localparam logic [9:0] PWM_PERIOD_RST  = 10'd450;
    localparam logic [7:0] TICKS_PER_S_RST = 8'd20;
    localparam logic [4:0] TOD_HOUR_RST    = 5'd21;
    localparam logic [5:0] TOD_MINUTE_RST  = 6'd42;
    localparam logic [5:0] TOD_SECOND_RST  = 6'd38;
    localparam logic [5:0] CD_SECOND_RST   = 6'd10;

    // Temperature band offsets below the upper threshold
    localparam logic signed [9:0] BAND_WIDE   = 10'sd15;
    localparam logic signed [9:0] BAND_NARROW = 10'sd10;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] temperature;
        logic [4:0] hours_in;
        logic [5:0] minutes_in;
        logic [5:0] seconds_in;
        logic [2:0] level_in;
    } t_in_item;

    typedef struct packed {
        logic       fan_on;
        logic       alarm;
        logic [2:0] speed_level;
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [5:0] clock_second;
        logic [4:0] remain_hour;
        logic [5:0] remain_minute;
        logic [5:0] remain_second;
    } t_out_item;

    // Duty for a speed level; levels above the table give zero
    function automatic logic [DUTY_W-1:0] duty_of(input logic [2:0] lv);
        case (lv)
            3'd0:    duty_of = 10'd0;
            3'd1:    duty_of = 10'd150;
            3'd2:    duty_of = 10'd200;
            3'd3:    duty_of = 10'd350;
            3'd4:    duty_of = 10'd450;
            default: duty_of = 10'd0;
        endcase
    endfunction

endpackage

// File: sv/fan_pwm_timer_controller.sv
// Top level of the fan PWM timer controller: state, per-item update and result register.
// Depends on fpt_pkg.
//
// Each input item (a 50 ms tick or a command) is handled in one pass of short
// counter and compare logic and updates the state at the edge it is accepted;
// its status item enters the output register at that same edge. One item is
// accepted every cycle while the output register is empty or being emptied,
// so the sustained rate is one item per clock while the receiver keeps up.
// Configuration writes are taken at any time (ready is always high) and
// belong only in idle periods. No clearing pass is needed after reset.
module fan_pwm_timer_controller #(
    parameter int PWM_COUNTER_BITS = fpt_pkg::PWM_COUNTER_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  fpt_pkg::t_in_item                 i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output fpt_pkg::t_out_item                o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fpt_pkg::*;

    localparam int PcW  = PWM_COUNTER_BITS;
    localparam int CmpW = (PcW > DUTY_W) ? PcW : DUTY_W;

    // Configuration registers
    logic [1:0] r_mode;
    logic [2:0] r_manual_level;
    logic [6:0] r_temp_high, r_temp_low;
    logic [9:0] r_pwm_period;
    logic [7:0] r_tps;

    // Working state
    logic [7:0]        r_tick_count, n_tick_count;
    logic [PcW-1:0]    r_pwm_count, n_pwm_count;
    logic [DUTY_W-1:0] r_duty, n_duty;
    logic [2:0]        r_level, n_level;
    logic [4:0]        r_tod_h, n_tod_h, r_cd_h, n_cd_h;
    logic [5:0]        r_tod_m, n_tod_m, r_tod_s, n_tod_s;
    logic [5:0]        r_cd_m, n_cd_m, r_cd_s, n_cd_s;
    logic              r_expired, n_expired;
    logic              r_fan, n_fan;

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    logic in_acc;
    logic [4:0] sat_h;
    logic [5:0] sat_m, sat_s;
    logic [PcW-1:0] pc_inc;
    logic [CmpW-1:0] pc_x, duty_x, period_x;
    logic signed [9:0] t_s, th_s, tl_s, th_wide, th_narrow;
    logic [2:0] auto_lv;

    assign o_ready     = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // Saturated time values for the load commands
    assign sat_h = (i_data.hours_in   > HOUR_MAX)   ? HOUR_MAX   : i_data.hours_in;
    assign sat_m = (i_data.minutes_in > MINSEC_MAX) ? MINSEC_MAX : i_data.minutes_in;
    assign sat_s = (i_data.seconds_in > MINSEC_MAX) ? MINSEC_MAX : i_data.seconds_in;

    // Temperature bands, signed since the threshold minus offset may go negative
    assign t_s       = signed'({2'b00, i_data.temperature});
    assign th_s      = signed'({3'b000, r_temp_high});
    assign tl_s      = signed'({3'b000, r_temp_low});
    assign th_wide   = th_s - BAND_WIDE;
    assign th_narrow = th_s - BAND_NARROW;

    always_comb begin
        if (t_s <= th_wide && t_s >= tl_s) begin
            auto_lv = 3'd1;
        end else if (t_s <= th_narrow && t_s >= th_wide) begin
            auto_lv = 3'd2;
        end else if (t_s > th_narrow && t_s >= tl_s) begin
            auto_lv = 3'd3;
        end else if (t_s > th_s) begin
            auto_lv = 3'd4;
        end else if (t_s <= tl_s) begin
            auto_lv = 3'd0;
        end else begin
            auto_lv = r_level;
        end
    end

    // Next state for one item
    always_comb begin
        n_tick_count = r_tick_count;
        n_pwm_count  = r_pwm_count;
        n_duty       = r_duty;
        n_level      = r_level;
        n_tod_h      = r_tod_h;
        n_tod_m      = r_tod_m;
        n_tod_s      = r_tod_s;
        n_cd_h       = r_cd_h;
        n_cd_m       = r_cd_m;
        n_cd_s       = r_cd_s;
        n_expired    = r_expired;
        n_fan        = r_fan;
        pc_inc       = r_pwm_count + 1'b1;
        pc_x         = CmpW'(pc_inc);
        duty_x       = CmpW'(r_duty);
        period_x     = CmpW'(r_pwm_period);

        case (i_data.action)
            ACT_TICK: begin
                n_tick_count = r_tick_count + 8'd1;
                if (n_tick_count == r_tps) begin
                    n_tick_count = 8'd0;
                    // time of day
                    if (r_tod_s < MINSEC_MAX) begin
                        n_tod_s = r_tod_s + 6'd1;
                    end else begin
                        n_tod_s = 6'd0;
                        if (r_tod_m < MINSEC_MAX) begin
                            n_tod_m = r_tod_m + 6'd1;
                        end else begin
                            n_tod_m = 6'd0;
                            if (r_tod_h < HOUR_MAX) begin
                                n_tod_h = r_tod_h + 5'd1;
                            end else begin
                                n_tod_h = 5'd0;
                            end
                        end
                    end
                    // run countdown, only while the fan has a duty
                    if (r_duty != '0) begin
                        if (r_cd_s != 6'd0) begin
                            n_cd_s = r_cd_s - 6'd1;
                        end else if (r_cd_m != 6'd0) begin
                            n_cd_s = MINSEC_MAX;
                            n_cd_m = r_cd_m - 6'd1;
                        end else if (r_cd_h != 5'd0) begin
                            n_cd_s = MINSEC_MAX;
                            n_cd_m = MINSEC_MAX;
                            n_cd_h = r_cd_h - 5'd1;
                        end else begin
                            n_duty    = '0;
                            n_expired = 1'b1;
                        end
                    end
                end
                // PWM against the duty left by the countdown
                duty_x      = CmpW'(n_duty);
                n_pwm_count = pc_inc;
                if (pc_x < duty_x) begin
                    n_fan = 1'b1;
                end else if (pc_x <= period_x) begin
                    n_fan = 1'b0;
                    if (pc_x == period_x) begin
                        n_pwm_count = '0;
                    end
                end
                // duty by mode
                case (r_mode)
                    MODE_MANUAL: begin
                        if (r_manual_level <= LEVEL_MAX) begin
                            n_level = r_manual_level;
                            n_duty  = duty_of(r_manual_level);
                        end
                    end
                    MODE_AUTO: begin
                        n_level = auto_lv;
                        if (auto_lv <= LEVEL_MAX) begin
                            n_duty = duty_of(auto_lv);
                        end
                    end
                    MODE_OFF: begin
                        n_level = 3'd0;
                        n_duty  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_LOAD_CD: begin
                n_cd_h = sat_h;
                n_cd_m = sat_m;
                n_cd_s = sat_s;
            end
            ACT_REMOTE: begin
                if (r_mode == MODE_REMOTE && i_data.level_in <= LEVEL_MAX) begin
                    n_level = i_data.level_in;
                    n_duty  = duty_of(i_data.level_in);
                end
            end
            ACT_SET_CLOCK: begin
                n_tod_h = sat_h;
                n_tod_m = sat_m;
                n_tod_s = sat_s;
            end
            ACT_ACK_ALARM: begin
                n_expired = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_MANUAL;
            r_manual_level <= 3'd0;
            r_temp_high    <= TEMP_HIGH_RST;
            r_temp_low     <= TEMP_LOW_RST;
            r_pwm_period   <= PWM_PERIOD_RST;
            r_tps          <= TICKS_PER_S_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CONTROL_MODE: r_mode         <= i_cfg_data[1:0];
                REG_MANUAL_LEVEL: r_manual_level <= i_cfg_data[2:0];
                REG_TEMP_HIGH:    r_temp_high    <= i_cfg_data[6:0];
                REG_TEMP_LOW:     r_temp_low     <= i_cfg_data[6:0];
                REG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data[9:0];
                REG_TICKS_PER_S:  r_tps          <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // State update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= 8'd0;
            r_pwm_count  <= '0;
            r_duty       <= '0;
            r_level      <= 3'd0;
            r_tod_h      <= TOD_HOUR_RST;
            r_tod_m      <= TOD_MINUTE_RST;
            r_tod_s      <= TOD_SECOND_RST;
            r_cd_h       <= 5'd0;
            r_cd_m       <= 6'd0;
            r_cd_s       <= CD_SECOND_RST;
            r_expired    <= 1'b0;
            r_fan        <= 1'b0;
        end else if (in_acc) begin
            r_tick_count <= n_tick_count;
            r_pwm_count  <= n_pwm_count;
            r_duty       <= n_duty;
            r_level      <= n_level;
            r_tod_h      <= n_tod_h;
            r_tod_m      <= n_tod_m;
            r_tod_s      <= n_tod_s;
            r_cd_h       <= n_cd_h;
            r_cd_m       <= n_cd_m;
            r_cd_s       <= n_cd_s;
            r_expired    <= n_expired;
            r_fan        <= n_fan;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.fan_on        <= n_fan;
            r_out.alarm         <= n_expired;
            r_out.speed_level   <= n_level;
            r_out.clock_hour    <= n_tod_h;
            r_out.clock_minute  <= n_tod_m;
            r_out.clock_second  <= n_tod_s;
            r_out.remain_hour   <= n_cd_h;
            r_out.remain_minute <= n_cd_m;
            r_out.remain_second <= n_cd_s;
        end
    end

    // Checks
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted item produced no result");

    a_ack_clears_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.action == ACT_ACK_ALARM |=> !o_data.alarm)
        else $error("alarm still set after acknowledge");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_MAX && r_level <= LEVEL_MAX)
        else $error("duty or level out of range");

    a_held_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_data.action == ACT_TICK && r_mode == MODE_OFF |=> r_duty == '0)
        else $error("duty nonzero after tick in held-off mode");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the fan PWM timer controller: drives ticks and commands,
// predicts every status item and compares it with what the block returns.
// Depends on fpt_pkg and fan_pwm_timer_controller.
`timescale 1ns / 1ps

module tb_top;
    import fpt_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 135;
    localparam int RANDOM_PHASES = 8;

    // Action codes the block has no use for
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // Duty per speed level, index 0 on the right
    localparam logic [4:0][9:0] LEVEL_DUTY = {10'd450, 10'd350, 10'd200, 10'd150, 10'd0};

    // Control mode of each random phase, phase 0 on the right
    localparam logic [7:0][1:0] MODE_PLAN = {MODE_AUTO, MODE_OFF, MODE_AUTO, MODE_MANUAL,
                                             MODE_AUTO, MODE_REMOTE, MODE_AUTO, MODE_MANUAL};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_in_item           i_data;
    logic               o_valid;
    logic               i_ready;
    t_out_item          o_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fan_pwm_timer_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted controller state and registers
    logic [1:0]  m_mode;
    logic [2:0]  m_man_lvl;
    logic [6:0]  m_t_hi, m_t_lo;
    logic [9:0]  m_period;
    logic [7:0]  m_tps;
    logic [7:0]  m_ticks;
    logic [PWM_COUNTER_BITS_DEF-1:0] m_pwm;
    logic [9:0]  m_duty;
    logic [2:0]  m_level;
    logic [4:0]  m_tod_h, m_cd_h;
    logic [5:0]  m_tod_m, m_tod_s, m_cd_m, m_cd_s;
    logic        m_expired, m_fan;

    t_in_item  item_backlog[$];
    t_out_item status_due[$];

    int  items_taken = 0;
    int  mismatches  = 0;
    int  cycles      = 0;
    int  tx_idle_pct = 6;
    int  rx_idle_pct = 55;
    logic in_taken = 1'b0;
    logic rx_hold  = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Status expected after one item; updates the predicted state
    function automatic t_out_item next_status(input t_in_item it);
        t_out_item st;
        int t, th, tl;
        logic [2:0] lv;
        case (it.action)
            ACT_TICK: begin
                m_ticks = m_ticks + 8'd1;
                if (m_ticks == m_tps) begin
                    m_ticks = '0;
                    // time of day
                    if (m_tod_s < MINSEC_MAX) m_tod_s = m_tod_s + 1'b1;
                    else begin
                        m_tod_s = '0;
                        if (m_tod_m < MINSEC_MAX) m_tod_m = m_tod_m + 1'b1;
                        else begin
                            m_tod_m = '0;
                            m_tod_h = (m_tod_h < HOUR_MAX) ? m_tod_h + 1'b1 : '0;
                        end
                    end
                    // run timer counts only while the fan has a duty
                    if (m_duty != '0) begin
                        if (m_cd_s > 0) m_cd_s = m_cd_s - 1'b1;
                        else begin
                            m_cd_s = MINSEC_MAX;
                            if (m_cd_m > 0) m_cd_m = m_cd_m - 1'b1;
                            else begin
                                m_cd_m = MINSEC_MAX;
                                if (m_cd_h > 0) m_cd_h = m_cd_h - 1'b1;
                                else begin
                                    m_cd_h = '0;
                                    m_cd_m = '0;
                                    m_cd_s = '0;
                                    m_duty = '0;
                                    m_expired = 1'b1;
                                end
                            end
                        end
                    end
                end
                // PWM against the duty left by the countdown; past the period the latch holds
                m_pwm = m_pwm + 1'b1;
                if (m_pwm < m_duty) m_fan = 1'b1;
                else if (m_pwm <= m_period) begin
                    m_fan = 1'b0;
                    if (m_pwm == m_period) m_pwm = '0;
                end
                // new duty by mode
                t  = int'(it.temperature);
                th = int'(m_t_hi);
                tl = int'(m_t_lo);
                case (m_mode)
                    MODE_MANUAL: begin
                        if (m_man_lvl <= LEVEL_MAX) begin
                            m_level = m_man_lvl;
                            m_duty  = LEVEL_DUTY[m_level];
                        end
                    end
                    MODE_AUTO: begin
                        lv = m_level;
                        if (t <= th - BAND_WIDE && t >= tl) lv = 3'd1;
                        else if (t <= th - BAND_NARROW && t >= th - BAND_WIDE) lv = 3'd2;
                        else if (t > th - BAND_NARROW && t >= tl) lv = 3'd3;
                        else if (t > th) lv = 3'd4;
                        else if (t <= tl) lv = 3'd0;
                        m_level = lv;
                        m_duty  = LEVEL_DUTY[lv];
                    end
                    MODE_OFF: begin
                        m_level = '0;
                        m_duty  = '0;
                    end
                    default: ;
                endcase
            end
            ACT_LOAD_CD: begin
                m_cd_h = (it.hours_in > HOUR_MAX) ? HOUR_MAX : it.hours_in;
                m_cd_m = (it.minutes_in > MINSEC_MAX) ? MINSEC_MAX : it.minutes_in;
                m_cd_s = (it.seconds_in > MINSEC_MAX) ? MINSEC_MAX : it.seconds_in;
            end
            ACT_REMOTE: begin
                if (m_mode == MODE_REMOTE && it.level_in <= LEVEL_MAX) begin
                    m_level = it.level_in;
                    m_duty  = LEVEL_DUTY[it.level_in];
                end
            end
            ACT_SET_CLOCK: begin
                m_tod_h = (it.hours_in > HOUR_MAX) ? HOUR_MAX : it.hours_in;
                m_tod_m = (it.minutes_in > MINSEC_MAX) ? MINSEC_MAX : it.minutes_in;
                m_tod_s = (it.seconds_in > MINSEC_MAX) ? MINSEC_MAX : it.seconds_in;
            end
            ACT_ACK_ALARM: m_expired = 1'b0;
            default: ;
        endcase
        st.fan_on        = m_fan;
        st.alarm         = m_expired;
        st.speed_level   = m_level;
        st.clock_hour    = m_tod_h;
        st.clock_minute  = m_tod_m;
        st.clock_second  = m_tod_s;
        st.remain_hour   = m_cd_h;
        st.remain_minute = m_cd_m;
        st.remain_second = m_cd_s;
        return st;
    endfunction

    // Random item, mostly ticks with temperatures near the band edges
    function automatic t_in_item random_item();
        t_in_item it;
        int r, base, t;
        it.action      = ACT_TICK;
        it.temperature = 8'($urandom_range(0, 255));
        it.hours_in    = 5'($urandom_range(0, 31));
        it.minutes_in  = 6'($urandom_range(0, 63));
        it.seconds_in  = 6'($urandom_range(0, 63));
        it.level_in    = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 62) begin
            case ($urandom_range(0, 4))
                0:       base = int'(m_t_lo);
                1:       base = int'(m_t_hi);
                2:       base = int'(m_t_hi) - 10;
                3:       base = int'(m_t_hi) - 15;
                default: base = $urandom_range(0, 255);
            endcase
            t = base + int'($urandom_range(0, 6)) - 3;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
            it.temperature = t[7:0];
        end else if (r < 72) begin
            it.action = ACT_LOAD_CD;
            if ($urandom_range(0, 3) != 0) begin
                it.hours_in   = '0;
                it.minutes_in = '0;
                it.seconds_in = 6'($urandom_range(0, 5));
            end
        end else if (r < 80) begin
            it.action   = ACT_REMOTE;
            it.level_in = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
        end else if (r < 86) begin
            it.action = ACT_SET_CLOCK;
            if ($urandom_range(0, 1) != 0) begin
                it.hours_in   = HOUR_MAX;
                it.minutes_in = MINSEC_MAX;
                it.seconds_in = 6'($urandom_range(50, 59));
            end
        end else if (r < 95) begin
            it.action = ACT_ACK_ALARM;
        end else begin
            it.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return it;
    endfunction

    task automatic offer(input logic [2:0] act, input logic [7:0] temp,
                         input logic [4:0] hh, input logic [5:0] mm,
                         input logic [5:0] ss, input logic [2:0] lv);
        t_in_item it;
        it.action      = act;
        it.temperature = temp;
        it.hours_in    = hh;
        it.minutes_in  = mm;
        it.seconds_in  = ss;
        it.level_in    = lv;
        item_backlog.push_back(it);
    endtask

    // Register write; the predicted copy follows at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_CONTROL_MODE: m_mode    = val[1:0];
            REG_MANUAL_LEVEL: m_man_lvl = val[2:0];
            REG_TEMP_HIGH:    m_t_hi    = val[6:0];
            REG_TEMP_LOW:     m_t_lo    = val[6:0];
            REG_PWM_PERIOD:   m_period  = val[9:0];
            REG_TICKS_PER_S:  m_tps     = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every item is in and every status item is out
    task automatic settle();
        while (item_backlog.size() != 0 || i_valid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Input acceptance and prediction
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
        if (i_valid && o_ready) begin
            status_due.push_back(next_status(i_data));
            items_taken++;
        end
    end

    // Driver: next item from the backlog, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (item_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= item_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver with random stalls
    always @(negedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long receiver hold-offs so the block backs up onto its input
    initial begin
        for (int k = 0; k < 2; k++) begin
            wait (items_taken >= 200 + 500 * k);
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // Monitor: compare each status item with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (status_due.size() == 0) begin
                $display("%0t: status item with nothing expected, got %h", $time, o_data);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("fan_on", int'(want.fan_on), int'(o_data.fan_on));
                check_field("alarm", int'(want.alarm), int'(o_data.alarm));
                check_field("speed_level", int'(want.speed_level),
                            int'(o_data.speed_level));
                check_field("clock_hour", int'(want.clock_hour), int'(o_data.clock_hour));
                check_field("clock_minute", int'(want.clock_minute),
                            int'(o_data.clock_minute));
                check_field("clock_second", int'(want.clock_second),
                            int'(o_data.clock_second));
                check_field("remain_hour", int'(want.remain_hour),
                            int'(o_data.remain_hour));
                check_field("remain_minute", int'(want.remain_minute),
                            int'(o_data.remain_minute));
                check_field("remain_second", int'(want.remain_second),
                            int'(o_data.remain_second));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sequence: reset, directed checks, then random phases
    initial begin : sequencer
        logic [6:0] hi, lo;
        logic [9:0] per;
        logic [7:0] tps;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        m_mode = MODE_MANUAL;  m_man_lvl = '0;
        m_t_hi = TEMP_HIGH_RST; m_t_lo = TEMP_LOW_RST;
        m_period = PWM_PERIOD_RST; m_tps = TICKS_PER_S_RST;
        m_ticks = '0; m_pwm = '0; m_duty = '0; m_level = '0;
        m_tod_h = TOD_HOUR_RST; m_tod_m = TOD_MINUTE_RST; m_tod_s = TOD_SECOND_RST;
        m_cd_h = '0; m_cd_m = '0; m_cd_s = CD_SECOND_RST;
        m_expired = 1'b0; m_fan = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: temperature extremes, spare codes, saturating loads
        offer(ACT_TICK, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_TICK, 8'd255, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_SPARE_FIRST, 8'd0, 5'd31, 6'd63, 6'd63, 3'd7);
        offer(ACT_SPARE_LAST, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_REMOTE, 8'd0, 5'd0, 6'd0, 6'd0, 3'd4);
        offer(ACT_SET_CLOCK, 8'd0, 5'd31, 6'd63, 6'd63, 3'd0);
        offer(ACT_LOAD_CD, 8'd0, 5'd31, 6'd63, 6'd63, 3'd0);
        offer(ACT_LOAD_CD, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_ACK_ALARM, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        settle();

        // midnight wrap and countdown expiry at full manual level
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_MANUAL));
        write_reg(REG_MANUAL_LEVEL, CFG_DATA_W'(LEVEL_MAX));
        write_reg(REG_TICKS_PER_S, 10'd1);
        write_reg(REG_PWM_PERIOD, 10'd1023);
        offer(ACT_SET_CLOCK, 8'd0, 5'd23, 6'd59, 6'd58, 3'd0);
        offer(ACT_LOAD_CD, 8'd0, 5'd0, 6'd0, 6'd2, 3'd0);
        repeat (4) offer(ACT_TICK, 8'd30, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_ACK_ALARM, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        settle();

        // remote mode, invalid remote level, extreme thresholds and rates
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_REMOTE));
        write_reg(REG_MANUAL_LEVEL, 10'd7);
        write_reg(REG_TEMP_HIGH, 10'd100);
        write_reg(REG_TEMP_LOW, 10'd0);
        write_reg(REG_PWM_PERIOD, 10'd1);
        write_reg(REG_TICKS_PER_S, 10'd255);
        offer(ACT_REMOTE, 8'd0, 5'd0, 6'd0, 6'd0, 3'd7);
        offer(ACT_REMOTE, 8'd0, 5'd0, 6'd0, 6'd0, 3'd3);
        offer(ACT_TICK, 8'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_TICK, 8'd255, 5'd0, 6'd0, 6'd0, 3'd0);
        settle();

        // held off with zero period and zero rate; remote ignored
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_OFF));
        write_reg(REG_PWM_PERIOD, 10'd0);
        write_reg(REG_TICKS_PER_S, 10'd0);
        offer(ACT_REMOTE, 8'd0, 5'd0, 6'd0, 6'd0, 3'd2);
        offer(ACT_TICK, 8'd128, 5'd0, 6'd0, 6'd0, 3'd0);
        settle();

        // manual mode with a level outside the table
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_MANUAL));
        write_reg(REG_MANUAL_LEVEL, 10'd5);
        offer(ACT_TICK, 8'd60, 5'd0, 6'd0, 6'd0, 3'd0);
        offer(ACT_TICK, 8'd60, 5'd0, 6'd0, 6'd0, 3'd0);
        settle();

        // random phases, each with its own settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                tx_idle_pct = 6;
                rx_idle_pct = 55;
            end else if (p < 6) begin
                tx_idle_pct = 55;
                rx_idle_pct = 6;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            hi = 7'($urandom_range(30, 90));
            lo = 7'($urandom_range(0, hi));
            if (p == 1) begin
                hi = 7'd127;
                lo = 7'd0;
            end else if (p == 5) begin
                hi = 7'd0;
                lo = 7'd127;
            end
            case (p)
                2:       per = 10'd0;
                3:       per = 10'd1023;
                6:       per = 10'd1;
                default: per = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(2, 40))
                                                           : 10'd450;
            endcase
            case (p)
                0:       tps = 8'd1;
                4:       tps = 8'd0;
                7:       tps = 8'd255;
                default: tps = 8'($urandom_range(1, 4));
            endcase
            write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_PLAN[p]));
            write_reg(REG_MANUAL_LEVEL, CFG_DATA_W'($urandom_range(0, 7)));
            write_reg(REG_TEMP_HIGH, CFG_DATA_W'(hi));
            write_reg(REG_TEMP_LOW, CFG_DATA_W'(lo));
            write_reg(REG_PWM_PERIOD, per);
            write_reg(REG_TICKS_PER_S, CFG_DATA_W'(tps));
            repeat (PHASE_ITEMS) item_backlog.push_back(random_item());
            settle();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
